FILE: rtl/core/chs_pkg.sv
// Shared constants, codes and interface types for the chained hash set.
package chs_pkg;

    localparam int BUCKET_BITS = 6;
    localparam int POOL_NODES  = 256;

    localparam int BUCKETS    = 1 << BUCKET_BITS;
    localparam int NODE_IDX_W = $clog2(POOL_NODES);
    localparam int NODE_BITS  = $clog2(POOL_NODES + 1);
    localparam int ELEM_W     = 64;
    localparam int MULT_W     = 32;
    localparam int COUNT_W    = 9;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;

    localparam logic [NODE_BITS-1:0] NIL_NODE  = NODE_BITS'(POOL_NODES);
    localparam logic [MULT_W-1:0]    MULT_INIT = 32'd2654435761;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD      = 2'd0,
        OP_REMOVE   = 2'd1,
        OP_CONTAINS = 2'd2,
        OP_NOP      = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HASH,
        S_HREAD,
        S_HWAIT,
        S_FWAIT,
        S_ADD_WR,
        S_WALK,
        S_CMP,
        S_UNLINK,
        S_FREE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                   we;
        logic [BUCKET_BITS-1:0] addr;
        logic [NODE_BITS-1:0]   data;
    } t_head_wr;

    typedef struct packed {
        logic                 we_value;
        logic                 we_link;
        logic [NODE_BITS-1:0] addr;
        logic [ELEM_W-1:0]    value;
        logic [NODE_BITS-1:0] link;
    } t_node_wr;

    typedef struct packed {
        logic [ELEM_W-1:0]    value;
        logic [NODE_BITS-1:0] link;
    } t_node_rd;

endpackage

FILE: rtl/core/chs_head_mem.sv
// Bucket head memory with per-bucket valid bits; an unwritten bucket reads as empty.
module chs_head_mem (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [chs_pkg::BUCKET_BITS-1:0] i_raddr,
    output logic [chs_pkg::NODE_BITS-1:0]   o_rdata,
    input  chs_pkg::t_head_wr               i_wr
);
    import chs_pkg::*;

    logic [NODE_BITS-1:0] r_mem [BUCKETS];
    logic [BUCKETS-1:0]   r_valid;
    logic [NODE_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.we) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_valid[i_raddr] ? r_mem[i_raddr] : NIL_NODE;
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/chs_node_mem.sv
// Node pool memory: element value and chain link per node, one read and one write port.
module chs_node_mem (
    input  logic                          i_clk,
    input  logic [chs_pkg::NODE_BITS-1:0] i_raddr,
    output chs_pkg::t_node_rd             o_rdata,
    input  chs_pkg::t_node_wr             i_wr
);
    import chs_pkg::*;

    logic [ELEM_W-1:0]    r_value [POOL_NODES];
    logic [NODE_BITS-1:0] r_link  [POOL_NODES];
    t_node_rd             r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we_value) begin
            r_value[i_wr.addr[NODE_IDX_W-1:0]] <= i_wr.value;
        end
        if (i_wr.we_link) begin
            r_link[i_wr.addr[NODE_IDX_W-1:0]] <= i_wr.link;
        end
        r_rdata.value <= r_value[i_raddr[NODE_IDX_W-1:0]];
        r_rdata.link  <= r_link[i_raddr[NODE_IDX_W-1:0]];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/chs_ctrl.sv
// Operation sequencer: hashing, chain walk, node allocation and release, result register.
module chs_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [chs_pkg::OP_W-1:0]        i_op,
    input  logic [chs_pkg::ELEM_W-1:0]      i_element,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [chs_pkg::STATUS_W-1:0]    o_status,
    output logic                            o_present,
    output logic [chs_pkg::COUNT_W-1:0]     o_count,
    input  logic                            i_cfg_wr_en,
    input  logic [chs_pkg::MULT_W-1:0]      i_cfg_wr_data,
    output logic [chs_pkg::BUCKET_BITS-1:0] o_head_raddr,
    input  logic [chs_pkg::NODE_BITS-1:0]   i_head_rdata,
    output chs_pkg::t_head_wr               o_head_wr,
    output logic [chs_pkg::NODE_BITS-1:0]   o_node_raddr,
    input  chs_pkg::t_node_rd               i_node_rdata,
    output chs_pkg::t_node_wr               o_node_wr
);
    import chs_pkg::*;

    t_state                 r_state, n_state;
    t_op                    r_op;
    logic [ELEM_W-1:0]      r_element;
    logic [MULT_W-1:0]      r_mult;
    logic [BUCKET_BITS-1:0] r_bucket;
    logic [BUCKET_BITS-1:0] n_bucket;
    logic [NODE_BITS-1:0]   r_head, r_cur, r_prev, r_next, r_node;
    logic [NODE_BITS-1:0]   r_free, r_fresh, r_total;
    logic [STATUS_W-1:0]    r_status;
    logic                   r_present;
    logic                   r_o_valid;
    logic [STATUS_W-1:0]    r_o_status;
    logic                   r_o_present;
    logic [COUNT_W-1:0]     r_o_count;
    logic                   accept;
    logic                   out_load;
    logic                   match;

    assign accept   = i_valid && o_ready;
    assign out_load = (r_state == S_DONE) && (!r_o_valid || i_ready);
    assign match    = (i_node_rdata.value == r_element);
    assign n_bucket = r_element[BUCKET_BITS-1:0] * r_mult[BUCKET_BITS-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_valid) n_state = S_HASH;
            S_HASH:   n_state = (r_op == OP_NOP) ? S_DONE : S_HREAD;
            S_HREAD:  n_state = S_HWAIT;
            S_HWAIT: begin
                if (r_op == OP_ADD) begin
                    if (r_free != NIL_NODE) begin
                        n_state = S_FWAIT;
                    end else if (r_fresh != NIL_NODE) begin
                        n_state = S_ADD_WR;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_state = S_WALK;
                end
            end
            S_FWAIT:  n_state = S_ADD_WR;
            S_ADD_WR: n_state = S_DONE;
            S_WALK:   n_state = (r_cur == NIL_NODE) ? S_DONE : S_CMP;
            S_CMP: begin
                if (!match) begin
                    n_state = S_WALK;
                end else if (r_op == OP_REMOVE) begin
                    n_state = S_UNLINK;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_UNLINK: n_state = S_FREE;
            S_FREE:   n_state = S_DONE;
            S_DONE:   if (out_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // memory access and handshake outputs
    always_comb begin
        o_ready      = 1'b0;
        o_head_raddr = r_bucket;
        o_node_raddr = r_cur;
        o_head_wr    = '0;
        o_node_wr    = '0;
        case (r_state)
            S_IDLE:  o_ready = 1'b1;
            S_HWAIT: o_node_raddr = r_free;
            S_ADD_WR: begin
                o_node_wr.we_value = 1'b1;
                o_node_wr.we_link  = 1'b1;
                o_node_wr.addr     = r_node;
                o_node_wr.value    = r_element;
                o_node_wr.link     = r_head;
                o_head_wr.we       = 1'b1;
                o_head_wr.addr     = r_bucket;
                o_head_wr.data     = r_node;
            end
            S_UNLINK: begin
                if (r_prev == NIL_NODE) begin
                    o_head_wr.we   = 1'b1;
                    o_head_wr.addr = r_bucket;
                    o_head_wr.data = r_next;
                end else begin
                    o_node_wr.we_link = 1'b1;
                    o_node_wr.addr    = r_prev;
                    o_node_wr.link    = r_next;
                end
            end
            S_FREE: begin
                o_node_wr.we_link = 1'b1;
                o_node_wr.addr    = r_cur;
                o_node_wr.link    = r_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mult    <= MULT_INIT;
            r_free    <= NIL_NODE;
            r_fresh   <= '0;
            r_total   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_mult <= i_cfg_wr_data;
            end
            case (r_state)
                S_HWAIT: begin
                    if (r_op == OP_ADD && r_free == NIL_NODE && r_fresh != NIL_NODE) begin
                        r_fresh <= r_fresh + 1'b1;
                    end
                end
                S_FWAIT:  r_free <= i_node_rdata.link;
                S_ADD_WR: r_total <= r_total + 1'b1;
                S_FREE: begin
                    r_free <= r_cur;
                    if (r_total != '0) begin
                        r_total <= r_total - 1'b1;
                    end
                end
                default: ;
            endcase
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_op      <= t_op'(i_op);
                    r_element <= i_element;
                    r_status  <= ST_OK;
                    r_present <= 1'b0;
                end
            end
            S_HASH: r_bucket <= n_bucket;
            S_HWAIT: begin
                r_head <= i_head_rdata;
                r_cur  <= i_head_rdata;
                r_prev <= NIL_NODE;
                r_node <= (r_free != NIL_NODE) ? r_free : r_fresh;
                if (r_op == OP_ADD && r_free == NIL_NODE && r_fresh == NIL_NODE) begin
                    r_status <= ST_FULL;
                end
            end
            S_WALK: begin
                if (r_cur == NIL_NODE && r_op == OP_REMOVE) begin
                    r_status <= ST_NOT_FOUND;
                end
            end
            S_CMP: begin
                if (match) begin
                    r_next    <= i_node_rdata.link;
                    r_present <= (r_op == OP_CONTAINS);
                end else begin
                    r_prev <= r_cur;
                    r_cur  <= i_node_rdata.link;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    r_o_status  <= r_status;
                    r_o_present <= r_present;
                    r_o_count   <= COUNT_W'(r_total);
                end
            end
            default: ;
        endcase
    end

    assign o_valid   = r_o_valid;
    assign o_status  = r_o_status;
    assign o_present = r_o_present;
    assign o_count   = r_o_count;

`ifndef ASSERT_OFF
    a_total_le_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= r_fresh)
        else $error("element count exceeds nodes handed out");

    a_fresh_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh <= NIL_NODE)
        else $error("fresh mark beyond pool");

    a_add_node_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ADD_WR |-> r_node != NIL_NODE)
        else $error("add writes the empty link");

    a_free_node_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FREE |-> r_cur != NIL_NODE)
        else $error("release of the empty link");

    a_total_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ADD_WR |=> r_total == $past(r_total) + 1'b1)
        else $error("count not advanced on add");
`endif

endmodule

FILE: rtl/core/chained_hash_set.sv
// Chained hash set top level: sequencer plus bucket head and node pool memories.
// Takes one word at a time and answers each with one result word. An add hashes,
// reads the bucket head and writes the node and the new head, with an extra link
// read when it reuses a freed node; op 3 goes from hashing straight to the result.
// Remove and contains walk the chain one node at a time until a match or the end,
// and a successful remove then unlinks and frees the node. The chain walk is set
// by the single-read node memory with its registered read: each node is read and
// then compared once its data returns. A new word is accepted in the cycle
// after a result is registered, even while it waits to be taken; the next result
// then waits until the previous one is taken. Bucket heads start empty through
// per-bucket valid bits, so no clearing pass follows reset. The multiplier
// register may be written only while idle.
module chained_hash_set (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [chs_pkg::OP_W-1:0]     i_op,
    input  logic [chs_pkg::ELEM_W-1:0]   i_element,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [chs_pkg::STATUS_W-1:0] o_status,
    output logic                         o_present,
    output logic [chs_pkg::COUNT_W-1:0]  o_count,
    input  logic                         i_cfg_wr_en,
    input  logic [chs_pkg::MULT_W-1:0]   i_cfg_wr_data
);
    import chs_pkg::*;

    logic [BUCKET_BITS-1:0] head_raddr;
    logic [NODE_BITS-1:0]   head_rdata;
    t_head_wr               head_wr;
    logic [NODE_BITS-1:0]   node_raddr;
    t_node_rd               node_rdata;
    t_node_wr               node_wr;

    chs_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_element     (i_element),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_present     (o_present),
        .o_count       (o_count),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_head_raddr  (head_raddr),
        .i_head_rdata  (head_rdata),
        .o_head_wr     (head_wr),
        .o_node_raddr  (node_raddr),
        .i_node_rdata  (node_rdata),
        .o_node_wr     (node_wr)
    );

    chs_head_mem u_head_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_raddr (head_raddr),
        .o_rdata (head_rdata),
        .i_wr    (head_wr)
    );

    chs_node_mem u_node_mem (
        .i_clk   (i_clk),
        .i_raddr (node_raddr),
        .o_rdata (node_rdata),
        .i_wr    (node_wr)
    );

endmodule
